// File: src/mfb_pkg.sv
// Package for the monochrome frame-buffer rectangle engine.
// Holds the command codes, sequencer states, row operations, fixed widths and the lit colour word.
// Depends on nothing; the top level and the checker import it.
`default_nettype none

package mfb_pkg;

	// Command codes carried on the mode field.
	typedef enum logic [2:0] {
		MODE_INVERT  = 3'd0,
		MODE_FILL    = 3'd1,
		MODE_OUTLINE = 3'd2,
		MODE_WINDOW  = 3'd3,
		MODE_PIXEL   = 3'd4,
		MODE_READ    = 3'd5
	} mode_t;

	// The two codes left over on the mode field; the block answers them at once with zero result fields and runs no sweep.
	localparam logic [2:0] MODE_UNUSED_A = 3'd6;
	localparam logic [2:0] MODE_UNUSED_B = 3'd7;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SWEEP
	} state_t;

	// What the shared row unit does to each row it visits.
	typedef enum logic [1:0] {
		OP_INV,
		OP_SET,
		OP_CLR,
		OP_READ
	} row_op_t;

	// A column sum of a 7-bit position and an 8-bit extent fits in 9 bits,
	// a row sum of a 6-bit position and a 7-bit extent in 8 bits.
	localparam int SPAN_W  = 9;
	localparam int RSPAN_W = 8;

	// Colour word that lights an image pixel.
	localparam logic [23:0] LIT_WORD = 24'hffffff;

endpackage

`default_nettype wire

// File: src/mfb_frame_mem.sv
// Row-organised frame store: one row of pixels per word.
// One write port and one registered read port. Depends on nothing.
`default_nettype none

module mfb_frame_mem #(
	parameter int ROWS = 64,
	parameter int COLS = 128
) (
	input  wire logic                    clk,
	input  wire logic                    wr_en,
	input  wire logic [$clog2(ROWS)-1:0] wr_addr,
	input  wire logic [COLS-1:0]         wr_data,
	input  wire logic                    rd_en,
	input  wire logic [$clog2(ROWS)-1:0] rd_addr,
	output logic      [COLS-1:0]         rd_data
);

	logic [COLS-1:0] mem [ROWS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: src/mono_framebuffer_rect_engine.sv
// Top level of the monochrome frame-buffer rectangle engine.
// Sequencer and shared row unit; instantiates mfb_frame_mem, imports mfb_pkg.
//
//  Channel   Direction  Handshake                 Payload
//  command   in         start high, busy low      mode, x_pos, y_pos, rect_width,
//                                                 rect_height, pixel_word
//  result    out        done high for one cycle   pixel_lit, image_done
//
// After reset is released the block sweeps the frame store once, writing one
// row of unlit pixels per cycle, with busy high until the last row is written.
// A command that runs the row sweep holds busy while the row unit reads one
// row and writes back the previous one in every cycle (a read writes nothing),
// so the single read and single write port set the pace; it then goes idle.
// A sweep that touches no on-screen row, such as an empty rectangle, still
// enters the sweep state and leaves it with no row read or written.
// A window command, an unused code or an image pixel with no open window
// raises no busy at all. The done strobe comes in the first cycle with busy
// low after the sweep (or after the accepting edge) and cannot be stalled.
`default_nettype none

module mono_framebuffer_rect_engine
	import mfb_pkg::*;
#(
	parameter int SCREEN_COLUMNS = 128,
	parameter int SCREEN_ROWS    = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  mode,
	input  wire logic [6:0]  x_pos,
	input  wire logic [5:0]  y_pos,
	input  wire logic [7:0]  rect_width,
	input  wire logic [6:0]  rect_height,
	input  wire logic [23:0] pixel_word,
	output logic             done,
	output logic             pixel_lit,
	output logic             image_done
);

	// Address width of the store and comparison widths that can hold any
	// on-screen index, the screen size itself and every command sum.
	localparam int COL_W  = $clog2(SCREEN_COLUMNS);
	localparam int RA_W   = $clog2(SCREEN_ROWS);
	localparam int CMP_W  = ($clog2(SCREEN_COLUMNS + 1) > SPAN_W) ?
	                        $clog2(SCREEN_COLUMNS + 1) : SPAN_W;
	localparam int RCMP_W = ($clog2(SCREEN_ROWS + 1) > RSPAN_W) ?
	                        $clog2(SCREEN_ROWS + 1) : RSPAN_W;

	state_t state_q, state_nx;

	// Command held for the row sweep.
	row_op_t           op_q;
	logic              outline_q;
	logic [CMP_W-1:0]  lo_q, hi_q;
	logic [RCMP_W-1:0] top_q, end_q;
	logic [RCMP_W-1:0] rd_row_q;
	logic              pend_done_q;
	logic              lit_q;

	// Row in flight between the read and the write-back.
	logic              v_s1;
	logic [RCMP_W-1:0] row_s1;

	logic [RA_W-1:0]   clr_row_q;

	// Image window and fill position.
	logic [6:0] window_left_q;
	logic [5:0] window_top_q;
	logic [7:0] window_width_q;
	logic [6:0] window_height_q;
	logic [7:0] image_column_q;
	logic [6:0] image_row_q;
	logic       image_active_q;

	logic res_vld_q, res_lit_q, res_done_q;

	// Frame store ports.
	logic                      mem_wr_en, mem_rd_en;
	logic [RA_W-1:0]           mem_wr_addr, mem_rd_addr;
	logic [SCREEN_COLUMNS-1:0] mem_wr_data, mem_rd_data;

	logic                      accept, sweep_cmd, issue, sweep_end, clear_last;
	logic [SPAN_W-1:0]         rect_hi, pix_col;
	logic [RSPAN_W-1:0]        rect_end, pix_row;
	logic                      rect_empty;
	logic [7:0]                img_row_inc;
	logic [8:0]                img_col_inc;
	logic                      img_col_wrap, img_finish;
	logic                      full_row, col_ok;
	logic [SCREEN_COLUMNS-1:0] mask, row_new;

	mfb_frame_mem #(
		.ROWS(SCREEN_ROWS),
		.COLS(SCREEN_COLUMNS)
	) u_mem (
		.clk    (clk),
		.wr_en  (mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data),
		.rd_en  (mem_rd_en),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data)
	);

	// Command decode. A transaction is taken only in the idle state.
	assign accept     = start && (state_q == ST_IDLE);
	assign rect_empty = (rect_width == 8'd0) || (rect_height == 7'd0);
	assign rect_hi    = SPAN_W'(x_pos) + SPAN_W'(rect_width);
	assign rect_end   = RSPAN_W'(y_pos) + RSPAN_W'(rect_height);
	assign pix_col    = SPAN_W'(window_left_q) + SPAN_W'(image_column_q);
	assign pix_row    = RSPAN_W'(window_top_q) + RSPAN_W'(image_row_q);

	// Fill position advance: down the column first, then to the next column.
	assign img_row_inc  = 8'(image_row_q) + 8'd1;
	assign img_col_inc  = 9'(image_column_q) + 9'd1;
	assign img_col_wrap = img_row_inc >= 8'(window_height_q);
	assign img_finish   = img_col_wrap && (img_col_inc >= 9'(window_width_q));

	// Rectangles and reads always run the row sweep; an image pixel only
	// when a window is open. Everything else answers at once.
	always_comb begin
		sweep_cmd = 1'b0;
		case (mode)
			MODE_INVERT, MODE_FILL, MODE_OUTLINE, MODE_READ: sweep_cmd = 1'b1;
			MODE_PIXEL: sweep_cmd = image_active_q;
			default: sweep_cmd = 1'b0;
		endcase
	end

	// A row is read while the sweep has rows left that lie on the screen.
	assign issue = (state_q == ST_SWEEP) && (rd_row_q < end_q) &&
	               (rd_row_q < RCMP_W'(SCREEN_ROWS));
	assign sweep_end  = (state_q == ST_SWEEP) && !issue && !v_s1;
	assign clear_last = clr_row_q == RA_W'(SCREEN_ROWS - 1);

	// Shared row unit. An outline lights its whole span on the top and bottom
	// rows and only the left and right edge columns elsewhere.
	assign full_row = !outline_q || (row_s1 == top_q) ||
	                  (row_s1 == end_q - RCMP_W'(1));

	always_comb begin
		for (int c = 0; c < SCREEN_COLUMNS; c++) begin
			if (full_row) begin
				mask[c] = (CMP_W'(c) >= lo_q) && (CMP_W'(c) < hi_q);
			end else begin
				mask[c] = (CMP_W'(c) == lo_q) || (CMP_W'(c) == hi_q - CMP_W'(1));
			end
		end
	end

	always_comb begin
		case (op_q)
			OP_INV:  row_new = mem_rd_data ^ mask;
			OP_SET:  row_new = mem_rd_data | mask;
			OP_CLR:  row_new = mem_rd_data & ~mask;
			default: row_new = mem_rd_data;
		endcase
	end

	assign col_ok = lo_q < CMP_W'(SCREEN_COLUMNS);

	// Next state.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clear_last) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept && sweep_cmd) begin
					state_nx = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (sweep_end) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_CLEAR;
		endcase
	end

	// Frame store control and busy.
	always_comb begin
		busy        = state_q != ST_IDLE;
		mem_rd_en   = issue;
		mem_rd_addr = rd_row_q[RA_W-1:0];
		mem_wr_en   = 1'b0;
		mem_wr_addr = row_s1[RA_W-1:0];
		mem_wr_data = row_new;
		case (state_q)
			ST_CLEAR: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = clr_row_q;
				mem_wr_data = '0;
			end
			ST_SWEEP: begin
				mem_wr_en = v_s1 && (op_q != OP_READ);
			end
			default: mem_wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	// Clearing pass counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_row_q <= '0;
		end else if (state_q == ST_CLEAR) begin
			clr_row_q <= clr_row_q + RA_W'(1);
		end
	end

	// Sweep pipeline valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			row_s1 <= rd_row_q;
		end
	end

	// Sweep command registers. The row counter starts on the top row and
	// walks down; an empty rectangle gets an empty row range.
	always_ff @(posedge clk) begin
		if (accept) begin
			case (mode)
				MODE_INVERT, MODE_FILL, MODE_OUTLINE: begin
					lit_q       <= 1'b0;
					pend_done_q <= 1'b0;
					op_q        <= (mode == MODE_INVERT) ? OP_INV : OP_SET;
					outline_q   <= mode == MODE_OUTLINE;
					lo_q        <= CMP_W'(x_pos);
					hi_q        <= CMP_W'(rect_hi);
					rd_row_q    <= RCMP_W'(y_pos);
					top_q       <= RCMP_W'(y_pos);
					end_q       <= rect_empty ? RCMP_W'(y_pos) : RCMP_W'(rect_end);
				end
				MODE_PIXEL: begin
					lit_q       <= 1'b0;
					outline_q   <= 1'b0;
					op_q        <= (pixel_word == LIT_WORD) ? OP_SET : OP_CLR;
					lo_q        <= CMP_W'(pix_col);
					hi_q        <= CMP_W'(pix_col) + CMP_W'(1);
					rd_row_q    <= RCMP_W'(pix_row);
					top_q       <= RCMP_W'(pix_row);
					end_q       <= RCMP_W'(pix_row) + RCMP_W'(1);
					pend_done_q <= img_finish;
				end
				default: begin
					lit_q       <= 1'b0;
					pend_done_q <= 1'b0;
					outline_q   <= 1'b0;
					op_q        <= OP_READ;
					lo_q        <= CMP_W'(x_pos);
					hi_q        <= CMP_W'(x_pos);
					rd_row_q    <= RCMP_W'(y_pos);
					top_q       <= RCMP_W'(y_pos);
					end_q       <= RCMP_W'(y_pos) + RCMP_W'(1);
				end
			endcase
		end else begin
			if (issue) begin
				rd_row_q <= rd_row_q + RCMP_W'(1);
			end
			if (v_s1 && (op_q == OP_READ)) begin
				lit_q <= col_ok && mem_rd_data[lo_q[COL_W-1:0]];
			end
		end
	end

	// Image window and fill position. Rectangles and reads leave them alone.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_left_q   <= '0;
			window_top_q    <= '0;
			window_width_q  <= '0;
			window_height_q <= '0;
			image_column_q  <= '0;
			image_row_q     <= '0;
			image_active_q  <= 1'b0;
		end else if (accept) begin
			if (mode == MODE_WINDOW) begin
				window_left_q   <= x_pos;
				window_top_q    <= y_pos;
				window_width_q  <= rect_width;
				window_height_q <= rect_height;
				image_column_q  <= '0;
				image_row_q     <= '0;
				image_active_q  <= !rect_empty;
			end else if ((mode == MODE_PIXEL) && image_active_q) begin
				if (!img_col_wrap) begin
					image_row_q <= img_row_inc[6:0];
				end else begin
					image_row_q <= '0;
					if (img_finish) begin
						image_column_q <= '0;
						image_active_q <= 1'b0;
					end else begin
						image_column_q <= img_col_inc[7:0];
					end
				end
			end
		end
	end

	// Result register: one strobe per transaction, fields zero outside it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q  <= 1'b0;
			res_lit_q  <= 1'b0;
			res_done_q <= 1'b0;
		end else if (accept && !sweep_cmd) begin
			res_vld_q  <= 1'b1;
			res_lit_q  <= 1'b0;
			res_done_q <= 1'b0;
		end else if (sweep_end) begin
			res_vld_q  <= 1'b1;
			res_lit_q  <= lit_q;
			res_done_q <= pend_done_q;
		end else begin
			res_vld_q  <= 1'b0;
			res_lit_q  <= 1'b0;
			res_done_q <= 1'b0;
		end
	end

	assign done       = res_vld_q;
	assign pixel_lit  = res_lit_q;
	assign image_done = res_done_q;

endmodule

`default_nettype wire

// File: src/mfb_checker.sv
// Port-level checker for the frame-buffer rectangle engine, with its bind.
// Sees only the top level's ports; depends on mfb_pkg and mono_framebuffer_rect_engine.
`default_nettype none

module mfb_checker
	import mfb_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic [2:0] mode,
	input wire logic       done,
	input wire logic       pixel_lit,
	input wire logic       image_done
);

	// A taken transaction either occupies the block or answers at once.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted transaction neither started nor answered");

	// Window commands and unused codes answer in the next cycle with zeros.
	a_window_answer: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy &&
		(mode == MODE_WINDOW || mode == MODE_UNUSED_A || mode == MODE_UNUSED_B)
		|=> done && !pixel_lit && !image_done)
		else $error("window or unused command not answered with zeros");

	// Results are only shown once the block has gone idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// Result fields stay low outside the strobe.
	a_fields_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> !pixel_lit && !image_done)
		else $error("result field high without strobe");

endmodule

bind mono_framebuffer_rect_engine mfb_checker u_mfb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.mode      (mode),
	.done      (done),
	.pixel_lit (pixel_lit),
	.image_done(image_done)
);

`default_nettype wire
